// File: rtl/tet_shape_quality_assert.svh
// Assertion macros used by the checker file of the tetrahedron quality block.
`ifndef TET_SHAPE_QUALITY_ASSERT_SVH
`define TET_SHAPE_QUALITY_ASSERT_SVH

// Checks that an expression holds at every clock edge outside reset.
`define TSQ_ASSERT(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
		else $error("tet_shape_quality check failed");

// Checks that a consequence holds in the same cycle as its condition.
`define TSQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("tet_shape_quality check failed");

`endif

// File: rtl/tsq_pkg.sv
// Types, widths, index tables and step functions of the tetrahedron quality block.
package tsq_pkg;

	localparam int COORD_BITS = 20;
	localparam int QUALITY_BITS = 16;
	localparam int QUALITY_FRAC_BITS_DEF = 16;

	localparam int SH = (COORD_BITS > 20) ? COORD_BITS - 20 : 0;
	localparam int PW = COORD_BITS - SH;
	localparam int EW = PW + 1;
	localparam int PRW = 2 * EW;
	localparam int CW = PRW + 1;
	localparam int CMW = CW - 1;
	localparam int FSQW = 2 * CMW;
	localparam int FRW = FSQW + 2;
	localparam int FST = FRW / 2;
	localparam int RW = FST + 3;
	localparam int ESQW = 2 * (EW - 1);
	localparam int ERW = ESQW + 2;
	localparam int EST = ERW / 2;
	localparam int DPW = EW + CW;
	localparam int DETW = DPW + 2;
	localparam int DMW = DETW;
	localparam int SW = FST + 2;
	localparam int DNW = SW + EST;
	localparam int NSQ = (FST + 1) / 2;

	localparam int NEDGE = 6;
	localparam int NFACE = 4;
	localparam int NCROSS = 5;
	localparam int DET_CROSS = 4;
	localparam int DET_EDGE = 3;

	// Edge i runs from corner EDGE_B[i] to corner EDGE_A[i].
	localparam int EDGE_A [NEDGE] = '{0, 1, 2, 0, 1, 2};
	localparam int EDGE_B [NEDGE] = '{1, 2, 0, 3, 3, 3};
	// Cross products: four faces, then the one used for the triple product.
	localparam int CR_U [NCROSS] = '{0, 0, 4, 2, 0};
	localparam int CR_V [NCROSS] = '{1, 4, 1, 5, 2};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] az;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic signed [COORD_BITS-1:0] bz;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [COORD_BITS-1:0] cz;
		logic signed [COORD_BITS-1:0] dx;
		logic signed [COORD_BITS-1:0] dy;
		logic signed [COORD_BITS-1:0] dz;
	} item_t;

	typedef struct packed {
		logic [QUALITY_BITS-1:0] quality;
		logic                    degenerate;
	} result_t;

	typedef struct packed {
		logic [RW-1:0]  rem;
		logic [FST-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [FRW-1:0] rad;
		sq_t            sq;
	} froot_t;

	typedef struct packed {
		logic [ERW-1:0] rad;
		sq_t            sq;
	} eroot_t;

	// One digit of a restoring square root.
	function automatic sq_t sq_step(sq_t cur, logic [1:0] b);
		logic [RW-1:0] r2;
		logic [RW-1:0] trial;
		sq_t nxt;
		r2 = {cur.rem[RW-3:0], b};
		trial = RW'({cur.root, 2'b01});
		if (r2 >= trial) begin
			nxt.rem = r2 - trial;
			nxt.root = {cur.root[FST-2:0], 1'b1};
		end else begin
			nxt.rem = r2;
			nxt.root = {cur.root[FST-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// Up to two root digits of a face norm.
	function automatic froot_t froot_step(froot_t x, int n);
		froot_t y;
		y = x;
		for (int j = 0; j < 2; j++) begin
			if (j < n) begin
				y.sq = sq_step(y.sq, y.rad[FRW-1 -: 2]);
				y.rad = y.rad << 2;
			end
		end
		return y;
	endfunction

	function automatic eroot_t eroot_step(eroot_t x);
		eroot_t y;
		y.sq = sq_step(x.sq, x.rad[ERW-1 -: 2]);
		y.rad = x.rad << 2;
		return y;
	endfunction

endpackage

// File: rtl/tet_shape_quality.sv
// Tetrahedron shape quality: inradius over longest edge, as a pipelined datapath.
// A tetrahedron is taken in every cycle in which start is high; busy is always low.
// Each result appears with done for one cycle. An item passes through the edge, product
// and cross-product stages, the 22-stage square-root pipeline with up to two face-norm
// root digits per stage, the denominator stages and the divider that produces up to two
// quotient bits per stage. Results leave in order, one per item.
// There is no back-pressure: the receiver must take each result in the cycle that
// done is high.
module tet_shape_quality #(
	parameter int QUALITY_FRAC_BITS = tsq_pkg::QUALITY_FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tsq_pkg::item_t  item,
	output logic            busy,
	output logic            done,
	output tsq_pkg::result_t result
);
	import tsq_pkg::*;

	localparam int QB = (QUALITY_FRAC_BITS < QUALITY_BITS) ? QUALITY_FRAC_BITS : QUALITY_BITS;
	localparam int NUMW = DMW + QUALITY_FRAC_BITS;
	localparam int DVW = ((NUMW > DNW + QB) ? NUMW : DNW + QB) + 1;
	localparam int NDV = (QB + 1) / 2;
	localparam int LATENCY = 6 + NSQ + 3 + NDV + 1;
	localparam logic [QUALITY_BITS-1:0] QMAX = QUALITY_BITS'((1 << QB) - 1);
	localparam int HW = (CMW + 1) / 2;
	localparam int PPW = 2 * HW;

	typedef struct packed {
		logic [DVW-1:0] rem;
		logic [DNW-1:0] den;
		logic [QB-1:0]  quo;
		logic           sat;
		logic           deg;
	} dv_t;

	// Restoring division: up to two quotient bits, starting at step k.
	function automatic dv_t dv_step(dv_t x, int k);
		dv_t y;
		logic [DVW-1:0] dsh;
		y = x;
		for (int j = 0; j < 2; j++) begin
			if (k + j < QB) begin
				dsh = DVW'(y.den) << (QB - 1 - k - j);
				if (y.rem >= dsh) begin
					y.rem = y.rem - dsh;
					y.quo = y.quo | (QB'(1) << (QB - 1 - k - j));
				end
			end
		end
		return y;
	endfunction

	logic [COORD_BITS-1:0] crd [12];
	logic [PW-1:0] pt [4][3];
	logic [CMW-1:0] cmag [NFACE][3];

	logic signed [EW-1:0]   e_s1 [NEDGE][3];
	logic signed [PRW-1:0]  pp_s2 [NCROSS][3][2];
	logic [ESQW-1:0]        es_s2 [NEDGE][3];
	logic signed [EW-1:0]   e3_s2 [3];
	logic signed [CW-1:0]   c_s3 [NCROSS][3];
	logic [ERW-1:0]         esum_s3 [NEDGE];
	logic signed [EW-1:0]   e3_s3 [3];
	logic [PPW-1:0]         fhh_s4 [NFACE][3];
	logic [PPW-1:0]         fhl_s4 [NFACE][3];
	logic [PPW-1:0]         fll_s4 [NFACE][3];
	logic signed [DPW-1:0]  dp_s4 [3];
	logic [ERW-1:0]         emax_s4 [3];
	logic [FSQW-1:0]        fsq_s5 [NFACE][3];
	logic signed [DPW-1:0]  dp_s5 [3];
	logic [ERW-1:0]         emax_s5 [3];
	logic [FRW-1:0]         frad_s6 [NFACE];
	logic signed [DETW-1:0] det_s6;
	logic [ERW-1:0]         best_s6;
	froot_t                 fr_s [NSQ][NFACE];
	eroot_t                 er_s [NSQ];
	logic [DMW-1:0]         detm_s [NSQ];
	logic [SW-1:0]          sum_s7;
	logic [EST-1:0]         len_s7;
	logic [DMW-1:0]         detm_s7;
	logic [DNW-1:0]         den_s8;
	logic [NUMW-1:0]        num_s8;
	logic                   deg_s8;
	dv_t                    dv_s9;
	dv_t                    dv_s [NDV];
	result_t                result_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, done_q;
	logic vsq_s [NSQ];
	logic vdv_s [NDV];

	assign crd = '{item.ax, item.ay, item.az, item.bx, item.by, item.bz,
		item.cx, item.cy, item.cz, item.dx, item.dy, item.dz};

	// Offset binary keeps every coordinate difference exact.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 3; j++) begin
				pt[i][j] = PW'({~crd[i*3+j][COORD_BITS-1], crd[i*3+j][COORD_BITS-2:0]} >> SH);
			end
		end
	end

	always_comb begin
		for (int f = 0; f < NFACE; f++) begin
			for (int m = 0; m < 3; m++) begin
				cmag[f][m] = CMW'(c_s3[f][m] < 0 ? -c_s3[f][m] : c_s3[f][m]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			done_q <= 1'b0;
			for (int t = 0; t < NSQ; t++) vsq_s[t] <= 1'b0;
			for (int t = 0; t < NDV; t++) vdv_s[t] <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			for (int t = 0; t < NSQ; t++) vsq_s[t] <= (t == 0) ? v_s6 : vsq_s[(t == 0) ? 0 : t-1];
			v_s7 <= vsq_s[NSQ-1];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			for (int t = 0; t < NDV; t++) vdv_s[t] <= (t == 0) ? v_s9 : vdv_s[(t == 0) ? 0 : t-1];
			done_q <= vdv_s[NDV-1];
		end
	end

	// Edges, products, cross products, squares, the longest edge and the triple product.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NEDGE; i++) begin
			for (int j = 0; j < 3; j++) begin
				e_s1[i][j] <= EW'(signed'({1'b0, pt[EDGE_A[i]][j]}))
					- EW'(signed'({1'b0, pt[EDGE_B[i]][j]}));
			end
		end

		for (int c = 0; c < NCROSS; c++) begin
			for (int m = 0; m < 3; m++) begin
				pp_s2[c][m][0] <= e_s1[CR_U[c]][(m+1)%3] * e_s1[CR_V[c]][(m+2)%3];
				pp_s2[c][m][1] <= e_s1[CR_U[c]][(m+2)%3] * e_s1[CR_V[c]][(m+1)%3];
			end
		end
		for (int i = 0; i < NEDGE; i++) begin
			for (int j = 0; j < 3; j++) begin
				es_s2[i][j] <= ESQW'(e_s1[i][j] * e_s1[i][j]);
			end
		end
		for (int j = 0; j < 3; j++) e3_s2[j] <= e_s1[DET_EDGE][j];

		for (int c = 0; c < NCROSS; c++) begin
			for (int m = 0; m < 3; m++) c_s3[c][m] <= pp_s2[c][m][0] - pp_s2[c][m][1];
		end
		for (int i = 0; i < NEDGE; i++) begin
			esum_s3[i] <= ERW'(es_s2[i][0]) + ERW'(es_s2[i][1]) + ERW'(es_s2[i][2]);
		end
		e3_s3 <= e3_s2;

		// Each face component is squared from its two halves to keep the multipliers narrow.
		for (int f = 0; f < NFACE; f++) begin
			for (int m = 0; m < 3; m++) begin
				fhh_s4[f][m] <= PPW'(cmag[f][m][CMW-1:HW]) * PPW'(cmag[f][m][CMW-1:HW]);
				fhl_s4[f][m] <= PPW'(cmag[f][m][CMW-1:HW]) * PPW'(cmag[f][m][HW-1:0]);
				fll_s4[f][m] <= PPW'(cmag[f][m][HW-1:0]) * PPW'(cmag[f][m][HW-1:0]);
			end
		end
		for (int m = 0; m < 3; m++) dp_s4[m] <= e3_s3[m] * c_s3[DET_CROSS][m];
		for (int k = 0; k < 3; k++) begin
			emax_s4[k] <= (esum_s3[2*k] > esum_s3[2*k+1]) ? esum_s3[2*k] : esum_s3[2*k+1];
		end

		for (int f = 0; f < NFACE; f++) begin
			for (int m = 0; m < 3; m++) begin
				fsq_s5[f][m] <= (FSQW'(fhh_s4[f][m]) << (2 * HW))
					+ (FSQW'(fhl_s4[f][m]) << (HW + 1)) + FSQW'(fll_s4[f][m]);
			end
		end
		dp_s5 <= dp_s4;
		emax_s5 <= emax_s4;

		for (int f = 0; f < NFACE; f++) begin
			frad_s6[f] <= FRW'(fsq_s5[f][0]) + FRW'(fsq_s5[f][1]) + FRW'(fsq_s5[f][2]);
		end
		det_s6 <= DETW'(dp_s5[0]) + DETW'(dp_s5[1]) + DETW'(dp_s5[2]);
		if (emax_s5[0] >= emax_s5[1] && emax_s5[0] >= emax_s5[2]) begin
			best_s6 <= emax_s5[0];
		end else if (emax_s5[1] >= emax_s5[2]) begin
			best_s6 <= emax_s5[1];
		end else begin
			best_s6 <= emax_s5[2];
		end
	end

	// Square roots: face norms take up to two digits per stage, the longest edge at most one.
	always_ff @(posedge clk) begin
		for (int t = 0; t < NSQ; t++) begin
			if (t == 0) begin
				for (int f = 0; f < NFACE; f++) begin
					fr_s[0][f] <= froot_step('{rad: frad_s6[f], sq: '0}, 2);
				end
				er_s[0] <= eroot_step('{rad: best_s6, sq: '0});
				detm_s[0] <= DMW'(det_s6 < 0 ? -det_s6 : det_s6);
			end else begin
				for (int f = 0; f < NFACE; f++) begin
					fr_s[t][f] <= froot_step(fr_s[t-1][f], (2*t + 2 <= FST) ? 2 : FST - 2*t);
				end
				er_s[t] <= (t < EST) ? eroot_step(er_s[t-1]) : er_s[t-1];
				detm_s[t] <= detm_s[t-1];
			end
		end
	end

	// Surface sum, denominator, overflow test, the divider and the result register.
	always_ff @(posedge clk) begin
		sum_s7 <= SW'(fr_s[NSQ-1][0].sq.root) + SW'(fr_s[NSQ-1][1].sq.root)
			+ SW'(fr_s[NSQ-1][2].sq.root) + SW'(fr_s[NSQ-1][3].sq.root);
		len_s7 <= er_s[NSQ-1].sq.root[EST-1:0];
		detm_s7 <= detm_s[NSQ-1];

		den_s8 <= DNW'(sum_s7) * DNW'(len_s7);
		num_s8 <= NUMW'(detm_s7) << QUALITY_FRAC_BITS;
		deg_s8 <= (sum_s7 == '0) || (len_s7 == '0);

		dv_s9.rem <= DVW'(num_s8);
		dv_s9.den <= den_s8;
		dv_s9.quo <= '0;
		dv_s9.sat <= DVW'(num_s8) >= (DVW'(den_s8) << QB);
		dv_s9.deg <= deg_s8;

		for (int t = 0; t < NDV; t++) begin
			if (t == 0) dv_s[0] <= dv_step(dv_s9, 0);
			else dv_s[t] <= dv_step(dv_s[t-1], 2*t);
		end

		if (dv_s[NDV-1].deg) begin
			result_q.quality <= '0;
			result_q.degenerate <= 1'b1;
		end else begin
			result_q.quality <= dv_s[NDV-1].sat ? QMAX : QUALITY_BITS'(dv_s[NDV-1].quo);
			result_q.degenerate <= 1'b0;
		end
	end

	assign busy = 1'b0;
	assign done = done_q;
	assign result = result_q;

endmodule

// File: rtl/tsq_checker.sv
// Port-level checks of the tetrahedron quality block and their binding.
`include "tet_shape_quality_assert.svh"

module tsq_checker #(
	parameter int LATENCY = 1,
	parameter int QUALITY_FRAC_BITS = tsq_pkg::QUALITY_FRAC_BITS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input tsq_pkg::result_t result
);
	import tsq_pkg::*;

	localparam int QB = (QUALITY_FRAC_BITS < QUALITY_BITS) ? QUALITY_FRAC_BITS : QUALITY_BITS;
	localparam logic [QUALITY_BITS-1:0] QMAX = QUALITY_BITS'((1 << QB) - 1);

	// The pipeline never refuses a transaction.
	`TSQ_ASSERT(a_never_busy, clk, arst_n, !busy)
	`TSQ_ASSERT_IMP(a_done_after_start, clk, arst_n, done, $past(start, LATENCY))
	`TSQ_ASSERT_IMP(a_degenerate_zero, clk, arst_n, done && result.degenerate, result.quality == '0)
	`TSQ_ASSERT_IMP(a_quality_range, clk, arst_n, done && !result.degenerate, result.quality <= QMAX)

endmodule

bind tet_shape_quality tsq_checker #(
	.LATENCY(LATENCY),
	.QUALITY_FRAC_BITS(QUALITY_FRAC_BITS)
) u_tsq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);
